// ----- rtl/itoa_pkg.sv -----
// itoa_pkg: widths, default word size, divider status type and the digit character function
// for the integer to ASCII converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

   // Default width of the converted integer
   localparam int WORD_BITS_DEFAULT = 32;

   // Fixed field widths
   localparam int RADIX_BITS = 6;
   localparam int DIGIT_BITS = 6;
   localparam int CHAR_BITS  = 7;

   // Radix limits and reset value
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_DEC   = 6'd10;

   // Quotient bits resolved by the divider in one cycle
   localparam int STEP_BITS = 4;

   // ASCII codes
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 7'h37;  // 'A' minus ten
   localparam logic [DIGIT_BITS-1:0] DIGIT_TOP = 6'd35;

   // Divider result flag and remainder, one beat per digit
   typedef struct packed {
      logic                  done;
      logic [DIGIT_BITS-1:0] remainder;
   } div_status_type;

   // Map a digit to 0-9 / A-Z; anything above 35 gives 'Z'
   function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
      logic [DIGIT_BITS-1:0] dc;
      dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
      if (dc < 6'd10) begin
         return CHAR_ZERO + CHAR_BITS'(dc);
      end else begin
         return CHAR_ALPHA + CHAR_BITS'(dc);
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_to_ascii_radix.sv -----
// integer_to_ascii_radix: top level, sequencer, digit store and output register.
// Depends on itoa_pkg and itoa_div.
//
//  Channel | Ports                                   | Direction | Handshake
//  req     | req_valid, req_stall, req_value         | in        | valid / stall
//  rsp     | rsp_valid, rsp_stall, rsp_character,    | out       | valid / stall
//          | rsp_last                                |           |
//  csr     | csr_valid, csr_ready, csr_radix         | in        | valid / ready
//
// One item at a time. Each digit costs one division by the shared divider. Each character
// then passes through store read, load and hand over; the minus sign through load and hand over.
// A radix 2 value gives the longest text, a radix 36 value the shortest.
// Reset is synchronous and returns the radix to 10. A stall on rsp holds the beat and
// the sequencer; req_stall stays high until the last character is taken.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_radix #(
   parameter int WORD_BITS = itoa_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [WORD_BITS-1:0]            req_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [itoa_pkg::CHAR_BITS-1:0]       rsp_character,
   output logic                                 rsp_last,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0] csr_radix
);
   import itoa_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS + 1);
   localparam int IDX_BITS = $clog2(WORD_BITS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_SIGN   = 6'b000100,
      ST_READ   = 6'b001000,
      ST_LOAD   = 6'b010000,
      ST_WAIT   = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_character_ff, rsp_character_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [DIGIT_BITS-1:0] rd_data_ff;

   logic [DIGIT_BITS-1:0] digit_mem [WORD_BITS];

   logic                  req_accept;
   logic                  rsp_accept;
   logic                  is_neg;
   logic [WORD_BITS-1:0]  magnitude;
   logic                  div_start;
   logic [WORD_BITS-1:0]  div_dividend;
   logic [WORD_BITS-1:0]  div_quotient;
   div_status_type        div_status;
   logic                  wr_en;
   logic                  rd_en;
   logic [CNT_BITS-1:0]   count_next;
   logic [CNT_BITS-1:0]   count_prev;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;

   // Sign only in decimal; negate modulo the word
   assign is_neg     = (radix_ff == RADIX_DEC) && req_value[WORD_BITS-1];
   assign magnitude  = is_neg ? (~req_value + WORD_BITS'(1)) : req_value;

   assign count_next = count_ff + CNT_BITS'(1);
   assign count_prev = count_ff - CNT_BITS'(1);

   // Clamp radix writes into 2..36
   always_comb begin
      radix_in = radix_ff;
      if (csr_valid && csr_ready) begin
         if (csr_radix < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (csr_radix > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = csr_radix;
         end
      end
   end

   // Sequencer: divide out digits, then emit the sign, if any, and the digits most significant first
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      neg_in           = neg_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      div_start        = 1'b0;
      div_dividend     = div_quotient;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               neg_in       = is_neg;
               count_in     = '0;
               div_start    = 1'b1;
               div_dividend = magnitude;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               wr_en    = 1'b1;
               count_in = count_next;
               if ((div_quotient != '0) && (count_next != CNT_BITS'(WORD_BITS))) begin
                  div_start = 1'b1;
               end else begin
                  state_in = neg_ff ? ST_SIGN : ST_READ;
               end
            end
         end
         ST_SIGN: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = CHAR_MINUS;
            rsp_last_in      = 1'b0;
            state_in         = ST_WAIT;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = digit_to_char(rd_data_ff);
            rsp_last_in      = (count_ff == CNT_BITS'(1));
            count_in         = count_prev;
            state_in         = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_accept) begin
               rsp_valid_in = 1'b0;
               state_in     = rsp_last_ff ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         count_ff     <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         count_ff     <= count_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output beat payload
   always_ff @(posedge clock) begin
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   // Digit store: write each remainder, read back in reverse
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[count_ff[IDX_BITS-1:0]] <= div_status.remainder;
      end
      if (rd_en) begin
         rd_data_ff <= digit_mem[count_prev[IDX_BITS-1:0]];
      end
   end

   itoa_div #(
      .WORD_BITS (WORD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .radix    (radix_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // Checks
   a_accept_only_when_drained: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !rsp_valid_ff)
      else $error("input beat taken while a character is pending");

   a_radix_in_range: assert property (@(posedge clock) disable iff (reset)
      (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX))
      else $error("radix register out of range");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_ff) |=> (!rsp_valid_ff && !req_stall))
      else $error("block not idle after final character");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide phase");

endmodule

`default_nettype wire

// ----- rtl/itoa_div.sv -----
// itoa_div: shared iterative divider, word by 6-bit radix, STEP_BITS quotient bits a cycle.
// Depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_div #(
   parameter int WORD_BITS = itoa_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [WORD_BITS-1:0]            dividend,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0] radix,
   output logic [WORD_BITS-1:0]                 quotient,
   output itoa_pkg::div_status_type             status
);
   import itoa_pkg::*;

   localparam int STEPS    = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS = STEPS * STEP_BITS;
   localparam int CNT_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [PAD_BITS-1:0]   shift_ff, shift_in;
   logic [PAD_BITS-1:0]   quot_ff, quot_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;

   // Restoring division over STEP_BITS bits of the dividend
   always_comb begin
      logic [PAD_BITS-1:0]   sh;
      logic [PAD_BITS-1:0]   q;
      logic [DIGIT_BITS-1:0] r;
      logic [DIGIT_BITS:0]   t;
      sh = shift_ff;
      q  = quot_ff;
      r  = rem_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         t  = {r, sh[PAD_BITS-1]};
         sh = {sh[PAD_BITS-2:0], 1'b0};
         if (t >= {1'b0, radix}) begin
            r = DIGIT_BITS'(t - {1'b0, radix});
            q = {q[PAD_BITS-2:0], 1'b1};
         end else begin
            r = t[DIGIT_BITS-1:0];
            q = {q[PAD_BITS-2:0], 1'b0};
         end
      end

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = PAD_BITS'(dividend);
         quot_in  = '0;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = sh;
         quot_in  = q;
         rem_in   = r;
         cnt_in   = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign quotient         = quot_ff[WORD_BITS-1:0];
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking bench for integer_to_ascii_radix, decimal and other radices.
// Predicts each text character in SV and checks every rsp beat in order.
// Depends on itoa_pkg and the integer_to_ascii_radix RTL only.
`timescale 1ns / 1ps

module tb;
   import itoa_pkg::*;

   localparam int          WORD_W      = 32;
   localparam int          SETTLE_CYC  = 8;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
   } text_beat_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN,
      STALL_HEAVY
   } stall_mode_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [WORD_W-1:0]     req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAR_BITS-1:0]  rsp_character;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [RADIX_BITS-1:0] csr_radix = '0;

   text_beat_type         text_q[$];
   text_beat_type         oldest;
   logic [RADIX_BITS-1:0] radix_setting = RADIX_RESET;
   stall_mode_type        stall_mode    = STALL_NONE;
   int unsigned           cycle_count   = 0;
   int                    fail_count    = 0;

   integer_to_ascii_radix #(.WORD_BITS(WORD_W)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_radix     (csr_radix)
   );

   always #5 clock = ~clock;

   // Count cycles and abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver back-pressure, one pattern per mode
   always @(posedge clock) begin
      case (stall_mode)
         STALL_NONE:    rsp_stall <= 1'b0;
         STALL_RANDOM:  rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PATTERN: rsp_stall <= ((cycle_count % 7) < 3);
         default:       rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Compare every taken character beat with the oldest predicted one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (text_q.size() == 0) begin
            $error("unexpected beat: character %h last %b", rsp_character, rsp_last);
            fail_count++;
         end else begin
            oldest = text_q.pop_front();
            if (rsp_character !== oldest.character) begin
               $error("character: expected %h, actual %h", oldest.character, rsp_character);
               fail_count++;
            end
            if (rsp_last !== oldest.last) begin
               $error("last: expected %b, actual %b", oldest.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] raw);
      if (raw < RADIX_MIN) return RADIX_MIN;
      if (raw > RADIX_MAX) return RADIX_MAX;
      return raw;
   endfunction

   // Work out the text of one value in the current radix, push one beat per character
   function automatic void predict_text(input logic [WORD_W-1:0] value);
      logic [WORD_W-1:0]     mag;
      logic [WORD_W-1:0]     base;
      logic [DIGIT_BITS-1:0] digits[$];
      logic [DIGIT_BITS-1:0] d;
      logic                  neg;
      text_beat_type         beat;
      base = WORD_W'(radix_setting);
      neg  = (radix_setting == RADIX_DEC) && value[WORD_W-1];
      mag  = neg ? -value : value;
      // least significant digit first; zero still gives one digit
      do begin
         digits.push_back(DIGIT_BITS'(mag % base));
         mag = mag / base;
      end while (mag != 0);
      if (neg) begin
         beat.character = CHAR_MINUS;
         beat.last      = 1'b0;
         text_q.push_back(beat);
      end
      for (int i = digits.size() - 1; i >= 0; i--) begin
         d = digits[i];
         // '0'..'9' then 'A'..'Z'
         beat.character = (d < 10) ? CHAR_ZERO + CHAR_BITS'(d)
                                   : 7'h41 + CHAR_BITS'(d) - 7'd10;
         beat.last      = (i == 0);
         text_q.push_back(beat);
      end
   endfunction

   // Hold one value until taken; keep valid high when the next beat follows at once
   task automatic send_value(input logic [WORD_W-1:0] value, input bit keep);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      predict_text(value);
      if (!keep) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Wait until every predicted character has been taken, then let the block settle
   task automatic wait_idle();
      while (text_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_BITS-1:0] raw);
      wait_idle();
      csr_valid <= 1'b1;
      csr_radix <= raw;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      radix_setting  = clamp_radix(raw);
   endtask

   // Mix of full-range, small, negative, radix-power and extreme values
   function automatic logic [WORD_W-1:0] pick_value();
      logic [63:0] p;
      int          k;
      case ($urandom_range(0, 5))
         0, 1: return $urandom();
         2:    return $urandom_range(0, 99);
         3:    return -WORD_W'($urandom_range(1, 1000));
         4: begin
            p = 1;
            k = $urandom_range(1, 8);
            repeat (k) p = p * radix_setting;
            return WORD_W'(p) - WORD_W'($urandom_range(0, 1));
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'h0000_0000;
               1:       return 32'h0000_0001;
               2:       return 32'h7FFF_FFFF;
               3:       return 32'h8000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // Reset radix is decimal: sign handling, zero and the most negative value
   task automatic test_default_decimal();
      stall_mode <= STALL_NONE;
      send_value(32'd0, 1'b1);
      send_value(32'd1, 1'b1);
      send_value(-32'sd1, 1'b0);
      send_value(32'h7FFF_FFFF, 1'b0);
      send_value(32'h8000_0000, 1'b1);
      send_value(32'd10, 1'b1);
      send_value(-32'sd10, 1'b1);
      send_value(32'd1_000_000_000, 1'b0);
   endtask

   // Smallest and largest radix, then radix 16: longest and shortest text; negatives as bit patterns
   task automatic test_radix_extremes();
      stall_mode <= STALL_RANDOM;
      write_radix(RADIX_MIN);
      send_value(32'd0, 1'b1);
      send_value(32'hFFFF_FFFF, 1'b1);
      send_value(32'h8000_0000, 1'b0);
      send_value(32'd1, 1'b0);
      send_value(32'h5555_5555, 1'b0);
      write_radix(RADIX_MAX);
      send_value(32'd0, 1'b1);
      send_value(32'd35, 1'b1);
      send_value(32'd36, 1'b0);
      send_value(32'hFFFF_FFFF, 1'b0);
      send_value(32'h7FFF_FFFF, 1'b0);
      write_radix(6'd16);
      send_value(32'hDEAD_BEEF, 1'b1);
      send_value(-32'sd1, 1'b0);
   endtask

   // Out-of-range radix writes clamp to the nearest limit
   task automatic test_radix_clamp();
      stall_mode <= STALL_PATTERN;
      write_radix(6'd0);
      send_value(32'd5, 1'b0);
      write_radix(6'd1);
      send_value(32'd6, 1'b0);
      write_radix(6'd63);
      send_value(32'd35, 1'b0);
      write_radix(6'd37);
      send_value(32'd71, 1'b0);
   endtask

   // Random phases: new radix, stall mode and burst shape per phase
   task automatic test_random_phases();
      int  left;
      bit  bursty;
      bit  pause;
      bit  end_burst;
      for (int ph = 0; ph < 9; ph++) begin
         case ($urandom_range(0, 3))
            0:       write_radix($urandom_range(0, 63));
            1:       write_radix(RADIX_DEC);
            2:       write_radix($urandom_range(0, 1) ? RADIX_MIN : RADIX_MAX);
            default: write_radix($urandom_range(2, 36));
         endcase
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         bursty = ($urandom_range(0, 3) != 0);
         left   = 0;
         for (int n = 0; n < 31; n++) begin
            if (left == 0) left = bursty ? $urandom_range(1, 6) : 31;
            left--;
            // drain the block completely now and then
            pause     = (ph == 0 && n == 15) || ($urandom_range(0, 24) == 0);
            end_burst = (left == 0) || (n == 30) || pause;
            send_value(pick_value(), !end_burst);
            if (pause) begin
               wait_idle();
            end else if (end_burst && bursty) begin
               repeat ($urandom_range(1, 5)) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_decimal();
      test_radix_extremes();
      test_radix_clamp();
      test_random_phases();
      wait_idle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
